@@ hdl/rgbcc_pkg.sv @@
// ----------------------------------------------------------------------------
// RGB sensor color correction package
// Constants and small arithmetic helpers shared by the correction pipeline.
// ----------------------------------------------------------------------------
package rgbcc_pkg;

  // Default raw count width of the sensor channels.
  localparam int COUNT_WIDTH_DEF = 16;

  // Width of one corrected channel.
  localparam int OUT_W = 8;

  // Channel positions inside packed channel vectors.
  localparam int CH_R = 0;
  localparam int CH_G = 1;
  localparam int CH_B = 2;
  localparam int NUM_CH = 3;

  // LED-on gains: red by 17/10, blue by 27/20.
  localparam int RED_GAIN_NUM  = 17;
  localparam int RED_GAIN_DEN  = 10;
  localparam int BLUE_GAIN_NUM = 27;
  localparam int BLUE_GAIN_DEN = 20;

  // Normalization target and the LED-on clamp threshold.
  localparam int NORM_TARGET = 250;
  localparam int CLAMP_LIMIT = 255;

  // Greenish yellow test: 20 * red >= 17 * max.
  localparam int YEL_NUM = 17;
  localparam int YEL_DEN = 20;

  // Quotient bits produced by each divider stage.
  localparam int DIV_BITS_PER_STAGE = 2;

  // floor(x / 5) for x below 512, as a multiply by 205 / 1024.
  function automatic logic [OUT_W-1:0] div5(input logic [OUT_W:0] x);
    logic [16:0] prod;
    prod = 17'(x) * 17'd205;
    return {1'b0, prod[16:10]};
  endfunction

endpackage

@@ hdl/rgb_sensor_color_correction.sv @@
// ----------------------------------------------------------------------------
// RGB sensor color correction
// Turns raw red, green and blue sensor counts into 8-bit corrected channel
// values, with LED gain, normalization, ratio-based attenuation and a
// greenish-yellow fix-up.
// ----------------------------------------------------------------------------
//
//   Channel   Signals                                         Direction
//   -------   ---------------------------------------------   ---------
//   input     in_valid_i, in_stall_o, *_count_i                 in
//   output    out_valid_o, out_stall_i, *_out_o                 out
//   config    led_on_we_i, led_on_i                             in
//
// One beat is accepted every cycle while the output is not stalled; the pipeline
// is made of the gain multiply, the max stage, the restoring divider for 250/max
// and the two correction stages.
// Reset clears the valid bits of every stage and the LED register.
// A stall at the output freezes the whole pipeline; nothing is dropped.
// ----------------------------------------------------------------------------
module rgb_sensor_color_correction
  import rgbcc_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   led_on_we_i,
  input  logic                   led_on_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [COUNT_WIDTH-1:0] red_count_i,
  input  logic [COUNT_WIDTH-1:0] green_count_i,
  input  logic [COUNT_WIDTH-1:0] blue_count_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [OUT_W-1:0]       red_out_o,
  output logic [OUT_W-1:0]       green_out_o,
  output logic [OUT_W-1:0]       blue_out_o
);

  // Gained channel width, product widths and reciprocal constants.
  localparam int G_W       = COUNT_WIDTH + 1;
  localparam int PROD_W    = COUNT_WIDTH + 5;
  localparam int RECIP_W   = PROD_W + 1;
  localparam int MUL_W     = PROD_W + RECIP_W;
  localparam int SHIFT_R   = PROD_W + 4;
  localparam int SHIFT_B   = PROD_W + 5;
  localparam logic [RECIP_W-1:0] RECIP_R = RECIP_W'((2 ** SHIFT_R) / RED_GAIN_DEN + 1);
  localparam logic [RECIP_W-1:0] RECIP_B = RECIP_W'((2 ** SHIFT_B) / BLUE_GAIN_DEN + 1);
  localparam int NUM_W     = G_W + 8;
  localparam int DIV_STG   = OUT_W / DIV_BITS_PER_STAGE;

  logic led_on_q;
  logic advance;

  // Stage 1: LED gain.
  logic               s1_valid_q;
  logic [G_W-1:0]     s1_r_q, s1_g_q, s1_b_q;
  logic [G_W-1:0]     s1_r_d, s1_b_d;
  logic [PROD_W-1:0]  r_prod, b_prod;
  logic [MUL_W-1:0]   r_wide, b_wide;

  // Stage 2 and divider stages, index 0 is the divider input.
  logic                           dv_valid_q [DIV_STG+1];
  logic [NUM_CH-1:0][NUM_W-1:0]   dv_rem_q   [DIV_STG+1];
  logic [NUM_CH-1:0][NUM_W-1:0]   dv_rem_d   [DIV_STG+1];
  logic [NUM_CH-1:0][OUT_W-1:0]   dv_quo_q   [DIV_STG+1];
  logic [NUM_CH-1:0][OUT_W-1:0]   dv_quo_d   [DIV_STG+1];
  logic [NUM_CH-1:0][OUT_W-1:0]   dv_raw_q   [DIV_STG+1];
  logic [G_W-1:0]                 dv_max_q   [DIV_STG+1];
  logic                           dv_scale_q [DIV_STG+1];
  logic [G_W-1:0]                 s2_max_d;
  logic                           s2_scale_d;

  // Attenuation stage.
  logic                         at_valid_q;
  logic [NUM_CH-1:0][OUT_W-1:0] at_q, at_d;
  logic [OUT_W-1:0]             at_max_q, at_max_d;
  logic [NUM_CH-1:0][OUT_W-1:0] sc;
  logic [NUM_CH-1:0][10:0]      five_sc;
  logic [NUM_CH-1:0]            mid_band, low_band;
  logic [10:0]                  three_max, four_max;
  logic                         red_top, yel, keep_blue;
  logic [OUT_W-1:0]             blue_t;

  // Output stage.
  logic                         out_valid_q;
  logic [NUM_CH-1:0][OUT_W-1:0] out_q, out_d;
  logic [OUT_W-1:0]             least;
  logic                         fix_yel;

  assign advance     = !(out_valid_q && out_stall_i);
  assign in_stall_o  = !advance;
  assign out_valid_o = out_valid_q;
  assign red_out_o   = out_q[CH_R];
  assign green_out_o = out_q[CH_G];
  assign blue_out_o  = out_q[CH_B];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      led_on_q <= 1'b0;
    end else if (led_on_we_i) begin
      led_on_q <= led_on_i;
    end
  end

  // ---------------------------------------------------------------- gain
  always_comb begin
    r_prod = PROD_W'(red_count_i) * PROD_W'(RED_GAIN_NUM);
    b_prod = PROD_W'(blue_count_i) * PROD_W'(BLUE_GAIN_NUM);
    r_wide = MUL_W'(r_prod) * MUL_W'(RECIP_R);
    b_wide = MUL_W'(b_prod) * MUL_W'(RECIP_B);
    if (led_on_q) begin
      s1_r_d = G_W'(r_wide >> SHIFT_R);
      s1_b_d = G_W'(b_wide >> SHIFT_B);
    end else begin
      s1_r_d = G_W'(red_count_i);
      s1_b_d = G_W'(blue_count_i);
    end
  end

  // ---------------------------------------------------------------- max
  always_comb begin
    s2_max_d = (s1_r_q > s1_g_q) ? s1_r_q : s1_g_q;
    if (s1_b_q > s2_max_d) begin
      s2_max_d = s1_b_q;
    end
    if (led_on_q) begin
      s2_scale_d = s2_max_d > G_W'(CLAMP_LIMIT);
    end else begin
      s2_scale_d = s2_max_d != '0;
    end
  end

  // --------------------------------------------------------- divider
  // Each stage retires DIV_BITS_PER_STAGE quotient bits of x * 250 / max.
  // The quotient never exceeds 250 because no channel exceeds the max.
  for (genvar k = 0; k < DIV_STG; k++) begin : g_div
    always_comb begin
      logic [NUM_W-1:0] trial;
      dv_rem_d[k+1] = dv_rem_q[k];
      dv_quo_d[k+1] = dv_quo_q[k];
      for (int c = 0; c < NUM_CH; c++) begin
        for (int j = 0; j < DIV_BITS_PER_STAGE; j++) begin
          trial = NUM_W'(dv_max_q[k]) << (OUT_W - 1 - k * DIV_BITS_PER_STAGE - j);
          if (dv_rem_d[k+1][c] >= trial) begin
            dv_rem_d[k+1][c] = dv_rem_d[k+1][c] - trial;
            dv_quo_d[k+1][c][OUT_W - 1 - k * DIV_BITS_PER_STAGE - j] = 1'b1;
          end
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_valid_q[k+1] <= 1'b0;
      end else if (advance) begin
        dv_valid_q[k+1] <= dv_valid_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (advance) begin
        dv_rem_q[k+1]   <= dv_rem_d[k+1];
        dv_quo_q[k+1]   <= dv_quo_d[k+1];
        dv_raw_q[k+1]   <= dv_raw_q[k];
        dv_max_q[k+1]   <= dv_max_q[k];
        dv_scale_q[k+1] <= dv_scale_q[k];
      end
    end
  end

  // The divider input stage loads the numerators x * 250.
  always_comb begin
    dv_rem_d[0][CH_R] = NUM_W'(s1_r_q) * NUM_W'(NORM_TARGET);
    dv_rem_d[0][CH_G] = NUM_W'(s1_g_q) * NUM_W'(NORM_TARGET);
    dv_rem_d[0][CH_B] = NUM_W'(s1_b_q) * NUM_W'(NORM_TARGET);
    dv_quo_d[0]       = '0;
  end

  // ----------------------------------------------------- attenuation
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      sc[c] = dv_scale_q[DIV_STG] ? dv_quo_q[DIV_STG][c] : dv_raw_q[DIV_STG][c];
    end
    at_max_d = (sc[CH_R] > sc[CH_G]) ? sc[CH_R] : sc[CH_G];
    if (sc[CH_B] > at_max_d) begin
      at_max_d = sc[CH_B];
    end
    three_max = 11'(at_max_d) * 11'd3;
    four_max  = {1'b0, at_max_d, 2'b00};
    for (int c = 0; c < NUM_CH; c++) begin
      five_sc[c]  = 11'(sc[c]) * 11'd5;
      mid_band[c] = (five_sc[c] < four_max) && (five_sc[c] >= three_max);
      low_band[c] = five_sc[c] < three_max;
    end

    red_top   = at_max_d == sc[CH_R];
    yel       = red_top && ({1'b0, sc[CH_G]} >= {sc[CH_B], 1'b0})
                && (five_sc[CH_G] >= 11'(sc[CH_R]));
    keep_blue = red_top && (sc[CH_G] <= sc[CH_B]) && (five_sc[CH_B] >= 11'(sc[CH_R]));
    blue_t    = yel ? (sc[CH_B] >> 1) : sc[CH_B];

    for (int c = 0; c < NUM_CH; c++) begin
      at_d[c] = sc[c];
      if (mid_band[c]) begin
        at_d[c] = div5({sc[c], 1'b0});
      end else if (low_band[c]) begin
        at_d[c] = div5({1'b0, sc[c]});
      end
    end
    // In the low band, green is kept and blue is softened when red leads a yellowish hue.
    if (low_band[CH_G] && yel) begin
      at_d[CH_G] = sc[CH_G];
    end
    if (low_band[CH_B]) begin
      at_d[CH_B] = keep_blue ? blue_t : div5({1'b0, blue_t});
    end
  end

  // ---------------------------------------------------------- fix-up
  always_comb begin
    least = (at_q[CH_R] < at_q[CH_G]) ? at_q[CH_R] : at_q[CH_G];
    if (at_q[CH_B] < least) begin
      least = at_q[CH_B];
    end
    fix_yel = (at_max_q == at_q[CH_G])
              && (13'(at_q[CH_R]) * 13'(YEL_DEN) >= 13'(at_max_q) * 13'(YEL_NUM))
              && (least == at_q[CH_B]);
    out_d = at_q;
    if (fix_yel) begin
      out_d[CH_R] = at_max_q;
      out_d[CH_B] = div5({at_q[CH_B], 1'b0});
    end
  end

  // ------------------------------------------------------- registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q    <= 1'b0;
      dv_valid_q[0] <= 1'b0;
      at_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
    end else if (advance) begin
      s1_valid_q    <= in_valid_i;
      dv_valid_q[0] <= s1_valid_q;
      at_valid_q    <= dv_valid_q[DIV_STG];
      out_valid_q   <= at_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_r_q <= s1_r_d;
      s1_g_q <= G_W'(green_count_i);
      s1_b_q <= s1_b_d;

      dv_rem_q[0]         <= dv_rem_d[0];
      dv_quo_q[0]         <= dv_quo_d[0];
      dv_raw_q[0][CH_R]   <= s1_r_q[OUT_W-1:0];
      dv_raw_q[0][CH_G]   <= s1_g_q[OUT_W-1:0];
      dv_raw_q[0][CH_B]   <= s1_b_q[OUT_W-1:0];
      dv_max_q[0]         <= s2_max_d;
      dv_scale_q[0]       <= s2_scale_d;

      at_q     <= at_d;
      at_max_q <= at_max_d;

      out_q <= out_d;
    end
  end

endmodule
